@@ hdl/csvft_pkg.sv @@
// Shared types and constants for the CSV field tokenizer.
// Holds result records, kind and error codes, parse modes and delimiter codes.
// No dependencies.
package csvft_pkg;

    localparam int CharW = 16;

    localparam logic [2:0] KIND_CHAR  = 3'd0;
    localparam logic [2:0] KIND_FIELD = 3'd1;
    localparam logic [2:0] KIND_ROW   = 3'd2;
    localparam logic [2:0] KIND_ERROR = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_AFTER_QUOT = 2'd1;
    localparam logic [1:0] ERR_STRAY_QUOT = 2'd2;
    localparam logic [1:0] ERR_OPEN_QUOT  = 2'd3;

    localparam logic [2:0] MODE_UNQ    = 3'd0;
    localparam logic [2:0] MODE_INQ    = 3'd1;
    localparam logic [2:0] MODE_QPEND  = 3'd2;
    localparam logic [2:0] MODE_CLOSED = 3'd3;
    localparam logic [2:0] MODE_ERR    = 3'd4;

    localparam logic [CharW-1:0] CH_QUOTE = 16'h0022;
    localparam logic [CharW-1:0] CH_COMMA = 16'h002C;
    localparam logic [CharW-1:0] CH_CR    = 16'h000D;
    localparam logic [CharW-1:0] CH_LF    = 16'h000A;

    typedef struct packed {
        logic [2:0]       kind;
        logic [CharW-1:0] chr;
        logic [1:0]       err;
        logic             last;
    } t_result;

    // Up to three results caused by one input item, slot 0 first.
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_batch;

    function automatic t_result mk_res(logic [2:0] kind, logic [CharW-1:0] chr,
                                       logic [1:0] err);
        t_result r;
        r.kind = kind;
        r.chr  = chr;
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

@@ hdl/csv_field_tokenizer_core.sv @@
// Streaming CSV tokenizer. Takes one text code unit per request (tlast on the final
// unit) and returns field characters, field ends, row ends, errors and a done marker,
// each with tuser = kind and tlast on the last result caused by that unit. Throughput
// is one code unit per cycle while the consumer is ready: an input register feeds the
// parse decode, whose results go into a three-entry result buffer that drains one result
// per cycle while the consumer is ready. Units that produce no result (an opening quote,
// the LF of a CRLF) still pass through the input register. A final unit may produce up
// to three results, which holds off input while the buffer drains. After an error the
// parser ignores input until the final unit; rows already sent before the error are for
// the consumer to discard.
module csv_field_tokenizer_core #(
    parameter int CHAR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] code_unit
    input  logic        i_s_axis_tlast,   // end_of_text
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [15:0] char_out, [17:16] error_code, rest 0
    output logic [2:0]  o_m_axis_tuser,   // [2:0] kind
    output logic        o_m_axis_tlast    // last_of_run
);
    import csvft_pkg::*;

    localparam logic [CharW-1:0] CharMask = (CHAR_BITS >= CharW) ? {CharW{1'b1}} :
        CharW'((64'd1 << CHAR_BITS) - 64'd1);

    logic [CharW-1:0] in_char;
    t_result          res;

    // drop code unit bits above the character width
    assign in_char = i_s_axis_tdata & CharMask;

    csvft_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_char  (in_char),
        .i_last  (i_s_axis_tlast),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    assign o_m_axis_tdata = {6'd0, res.err, res.chr};
    assign o_m_axis_tuser = res.kind;
    assign o_m_axis_tlast = res.last;

endmodule

@@ hdl/csvft_parse.sv @@
// Parse state and per-item decode for the CSV field tokenizer.
// Turns one code unit plus the final flag into a batch of up to three results.
// Depends on csvft_pkg.
module csvft_parse (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_advance,
    input  logic [csvft_pkg::CharW-1:0] i_char,
    input  logic                      i_last,
    output csvft_pkg::t_batch         o_batch
);
    import csvft_pkg::*;

    logic [2:0] r_mode, n_mode;
    logic       r_cr_pending, n_cr_pending;
    logic       r_field_has_chars, n_field_has_chars;
    logic       r_row_has_fields, n_row_has_fields;

    always_comb begin
        logic       skip;
        logic       closed;
        logic       u_vld;
        logic       f_err;
        logic       f_row;
        logic [1:0] cnt;
        t_result    u_res;

        n_mode            = r_mode;
        n_cr_pending      = r_cr_pending;
        n_field_has_chars = r_field_has_chars;
        n_row_has_fields  = r_row_has_fields;
        skip   = 1'b0;
        closed = 1'b0;
        u_vld  = 1'b0;
        u_res  = mk_res(KIND_CHAR, '0, ERR_NONE);

        // LF right after a CR line end is part of the same line end
        if (r_cr_pending) begin
            n_cr_pending = 1'b0;
            if (i_char == CH_LF && r_mode == MODE_UNQ) begin
                skip = 1'b1;
            end
        end

        if (!skip) begin
            case (r_mode)
                MODE_INQ: begin
                    if (i_char == CH_QUOTE) begin
                        n_mode = MODE_QPEND;
                    end else begin
                        u_vld = 1'b1;
                        u_res = mk_res(KIND_CHAR, i_char, ERR_NONE);
                        n_field_has_chars = 1'b1;
                    end
                end
                MODE_QPEND: begin
                    if (i_char == CH_QUOTE) begin
                        u_vld = 1'b1;
                        u_res = mk_res(KIND_CHAR, i_char, ERR_NONE);
                        n_field_has_chars = 1'b1;
                        n_mode = MODE_INQ;
                    end else begin
                        closed = 1'b1;
                    end
                end
                MODE_CLOSED: begin
                    closed = 1'b1;
                end
                MODE_UNQ: begin
                    if (i_char == CH_QUOTE) begin
                        if (r_field_has_chars) begin
                            u_vld = 1'b1;
                            u_res = mk_res(KIND_ERROR, '0, ERR_STRAY_QUOT);
                            n_mode = MODE_ERR;
                            n_row_has_fields  = 1'b0;
                            n_field_has_chars = 1'b0;
                            n_cr_pending      = 1'b0;
                        end else begin
                            n_mode = MODE_INQ;
                        end
                    end else if (i_char == CH_COMMA) begin
                        u_vld = 1'b1;
                        u_res = mk_res(KIND_FIELD, '0, ERR_NONE);
                        n_row_has_fields  = 1'b1;
                        n_field_has_chars = 1'b0;
                    end else if (i_char == CH_CR || i_char == CH_LF) begin
                        u_vld = r_row_has_fields || r_field_has_chars;
                        u_res = mk_res(KIND_ROW, '0, ERR_NONE);
                        n_row_has_fields  = 1'b0;
                        n_field_has_chars = 1'b0;
                        n_cr_pending      = (i_char == CH_CR);
                    end else begin
                        u_vld = 1'b1;
                        u_res = mk_res(KIND_CHAR, i_char, ERR_NONE);
                        n_field_has_chars = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // after a closing quote only a delimiter may follow
            if (closed) begin
                if (i_char == CH_COMMA) begin
                    u_vld = 1'b1;
                    u_res = mk_res(KIND_FIELD, '0, ERR_NONE);
                    n_row_has_fields  = 1'b1;
                    n_field_has_chars = 1'b0;
                    n_mode = MODE_UNQ;
                end else if (i_char == CH_CR || i_char == CH_LF) begin
                    u_vld = r_row_has_fields || r_field_has_chars;
                    u_res = mk_res(KIND_ROW, '0, ERR_NONE);
                    n_row_has_fields  = 1'b0;
                    n_field_has_chars = 1'b0;
                    n_mode = MODE_UNQ;
                    n_cr_pending = (i_char == CH_CR);
                end else begin
                    u_vld = 1'b1;
                    u_res = mk_res(KIND_ERROR, '0, ERR_AFTER_QUOT);
                    n_mode = MODE_ERR;
                    n_row_has_fields  = 1'b0;
                    n_field_has_chars = 1'b0;
                    n_cr_pending      = 1'b0;
                end
            end
        end

        f_err = i_last && (n_mode == MODE_INQ);
        f_row = i_last && (n_row_has_fields || n_field_has_chars) &&
                (n_mode == MODE_UNQ || n_mode == MODE_QPEND || n_mode == MODE_CLOSED);

        // pack results into slots in order: unit, flush, done
        o_batch = '0;
        cnt = 2'd0;
        if (u_vld) begin
            o_batch.res[cnt] = u_res;
            cnt = cnt + 2'd1;
        end
        if (f_err) begin
            o_batch.res[cnt] = mk_res(KIND_ERROR, '0, ERR_OPEN_QUOT);
            cnt = cnt + 2'd1;
        end else if (f_row) begin
            o_batch.res[cnt] = mk_res(KIND_ROW, '0, ERR_NONE);
            cnt = cnt + 2'd1;
        end
        if (i_last) begin
            o_batch.res[cnt] = mk_res(KIND_DONE, '0, ERR_NONE);
            cnt = cnt + 2'd1;
        end
        if (cnt != 2'd0) begin
            o_batch.res[cnt - 2'd1].last = 1'b1;
        end
        o_batch.count = cnt;

        // the final unit starts a fresh text
        if (i_last) begin
            n_mode            = MODE_UNQ;
            n_cr_pending      = 1'b0;
            n_field_has_chars = 1'b0;
            n_row_has_fields  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= MODE_UNQ;
            r_cr_pending      <= 1'b0;
            r_field_has_chars <= 1'b0;
            r_row_has_fields  <= 1'b0;
        end else if (i_advance) begin
            r_mode            <= n_mode;
            r_cr_pending      <= n_cr_pending;
            r_field_has_chars <= n_field_has_chars;
            r_row_has_fields  <= n_row_has_fields;
        end
    end

endmodule

@@ hdl/csvft_emit.sv @@
// Result buffer for the CSV field tokenizer.
// Holds one batch of up to three results and sends them one per request.
// Depends on csvft_pkg.
module csvft_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  csvft_pkg::t_batch i_batch,
    output logic              o_free,
    output logic              o_tvalid,
    input  logic              i_tready,
    output csvft_pkg::t_result o_res
);
    import csvft_pkg::*;

    t_result [2:0] r_res;
    logic [1:0]    r_rem;
    logic          take;
    logic          load;

    assign o_tvalid = (r_rem != 2'd0);
    assign take     = o_tvalid && i_tready;
    assign o_free   = (r_rem == 2'd0) || (r_rem == 2'd1 && i_tready);
    assign load     = i_load && o_free;
    assign o_res    = r_res[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= 2'd0;
        end else if (load) begin
            r_rem <= i_batch.count;
        end else if (take) begin
            r_rem <= r_rem - 2'd1;
        end
    end

    // shift the batch down as results leave
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_batch.res;
        end else if (take) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

`ifndef SYNTHESIS
    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem == 2'd1 |-> r_res[0].last)
        else $error("final buffered result lacks last flag");

    a_no_early_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem == 2'd2 || r_rem == 2'd3) |-> !r_res[0].last)
        else $error("last flag set before end of batch");

    a_drain_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_rem == 2'd2 || r_rem == 2'd3) && i_tready) |=> r_rem == $past(r_rem) - 2'd1)
        else $error("buffer did not advance by one result");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tvalid && r_res[0].kind == KIND_ERROR) |-> r_res[0].err != ERR_NONE)
        else $error("error result without error code");
`endif

endmodule

@@ hdl/csvft_core.sv @@
// Input register stage of the CSV field tokenizer: holds one request and feeds
// the parse decode and the result buffer.
// Depends on csvft_pkg, csvft_parse and csvft_emit.
module csvft_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [csvft_pkg::CharW-1:0] i_char,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output csvft_pkg::t_result          o_res
);
    import csvft_pkg::*;

    logic                r_in_valid;
    logic [CharW-1:0]    r_in_char;
    logic                r_in_last;
    logic                move;
    logic                free;
    t_batch              batch;

    assign move    = r_in_valid && free;
    assign o_ready = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_char <= i_char;
            r_in_last <= i_last;
        end
    end

    csvft_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (move),
        .i_char    (r_in_char),
        .i_last    (r_in_last),
        .o_batch   (batch)
    );

    csvft_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_in_valid),
        .i_batch  (batch),
        .o_free   (free),
        .o_tvalid (o_valid),
        .i_tready (i_ready),
        .o_res    (o_res)
    );

endmodule
